>>> sv/csr_sparse_matrix_vector_multiply_assert.svh
// assertion macros used by csr_sparse_matrix_vector_multiply.sv
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CSM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define CSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/csr_spmv_pkg.sv
package csr_spmv_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TERM  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic REG_NUM_COLS = 1'b0;
    localparam logic [12:0] NUM_COLS_RESET = 13'd4096;

    // accumulator bounds in the widened sum
    localparam logic signed [64:0] SUM_HI = 65'sh0_0000_7FFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_LO = -SUM_HI - 65'sd1;
    localparam logic signed [47:0] ACC_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ACC_LO = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        column_index;
        logic signed [31:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        row_index;
        logic signed [47:0] row_sum;
        logic               bad_column;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic       bad;
    } t_stage;

endpackage

>>> sv/csr_spmv_stream_if.sv
interface csr_spmv_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/csr_spmv_vec_store.sv
module csr_spmv_vec_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  logic signed [31:0]  i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output logic signed [31:0]  o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/csr_spmv_mac.sv
module csr_spmv_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  csr_spmv_pkg::t_stage   i_s1,
    input  logic signed [31:0]     i_mat,
    input  logic signed [31:0]     i_vec,
    input  logic                   i_out_ready,
    output logic                   o_stall,
    output logic                   o_valid,
    output csr_spmv_pkg::t_out_item o_item
);

    csr_spmv_pkg::t_stage    r_s2;
    csr_spmv_pkg::t_stage    n_s2;
    logic signed [63:0]      r_s2_prod;
    logic signed [47:0]      r_acc;
    logic signed [47:0]      n_acc;
    logic [15:0]             r_row;
    logic [15:0]             n_row;
    logic                    r_bad_seen;
    logic                    n_bad_seen;
    logic                    r_sat_seen;
    logic                    n_sat_seen;
    logic                    r_out_valid;
    logic                    n_out_valid;
    csr_spmv_pkg::t_out_item r_out;

    logic signed [63:0]      w_prod_sh;
    logic signed [64:0]      w_sum;
    logic                    w_hi;
    logic                    w_lo;
    logic                    w_fire;
    logic                    w_close;

    // a close waits here only while the previous result is not taken
    assign o_stall = r_s2.valid && (r_s2.kind == csr_spmv_pkg::KIND_CLOSE)
                     && r_out_valid && !i_out_ready;
    assign w_fire  = r_s2.valid && !o_stall;
    assign w_close = w_fire && (r_s2.kind == csr_spmv_pkg::KIND_CLOSE);

    assign w_prod_sh = r_s2_prod >>> FRAC_BITS;
    assign w_sum = $signed({{17{r_acc[47]}}, r_acc}) + $signed({w_prod_sh[63], w_prod_sh});
    assign w_hi  = w_sum > csr_spmv_pkg::SUM_HI;
    assign w_lo  = w_sum < csr_spmv_pkg::SUM_LO;

    always_comb begin
        n_s2        = o_stall ? r_s2 : i_s1;
        n_acc       = r_acc;
        n_row       = r_row;
        n_bad_seen  = r_bad_seen;
        n_sat_seen  = r_sat_seen;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        if (w_fire) begin
            unique case (r_s2.kind)
                csr_spmv_pkg::KIND_TERM: begin
                    if (r_s2.bad) begin
                        n_bad_seen = 1'b1;
                    end else if (w_hi) begin
                        n_acc      = csr_spmv_pkg::ACC_HI;
                        n_sat_seen = 1'b1;
                    end else if (w_lo) begin
                        n_acc      = csr_spmv_pkg::ACC_LO;
                        n_sat_seen = 1'b1;
                    end else begin
                        n_acc = w_sum[47:0];
                    end
                end
                csr_spmv_pkg::KIND_CLOSE: begin
                    n_acc       = '0;
                    n_bad_seen  = 1'b0;
                    n_sat_seen  = 1'b0;
                    n_row       = r_row + 16'd1;
                    n_out_valid = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2        <= '0;
            r_acc       <= '0;
            r_row       <= '0;
            r_bad_seen  <= 1'b0;
            r_sat_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s2        <= n_s2;
            r_acc       <= n_acc;
            r_row       <= n_row;
            r_bad_seen  <= n_bad_seen;
            r_sat_seen  <= n_sat_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_s2_prod <= i_mat * i_vec;
        end
        if (w_close) begin
            r_out.row_index  <= r_row;
            r_out.row_sum    <= r_acc;
            r_out.bad_column <= r_bad_seen;
            r_out.saturated  <= r_sat_seen;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

>>> sv/csr_sparse_matrix_vector_multiply.sv
// path: a close_row input passes stage 1, stage 2 and the output register before its result is valid
// throughput: one item per cycle; input stalls only while a close_row reaches the
//   accumulate stage and the previous result is still held in the output register
// pipeline: vector store read, 32x32 multiply register, saturating accumulate
// reset: synchronous active low; clears pipeline, accumulator, flags and row count;
//   num_cols returns to 4096; vector store is not cleared and is undefined until loaded
`include "csr_sparse_matrix_vector_multiply_assert.svh"

module csr_sparse_matrix_vector_multiply #(
    parameter int MAX_COLS  = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    csr_spmv_stream_if.sink      i_in,
    csr_spmv_stream_if.source    o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = $clog2(MAX_COLS);

    logic [12:0]          r_num_cols;
    csr_spmv_pkg::t_stage r_s1;
    csr_spmv_pkg::t_stage n_s1;
    logic signed [31:0]   r_s1_data;
    logic signed [31:0]   w_vec;
    logic                 w_stall;
    logic                 w_accept;
    logic                 w_in_store;
    logic                 w_bad;
    logic [31:0]          w_col_ext;
    logic [AW-1:0]        w_addr;
    logic                 w_load;
    logic                 w_term;
    logic                 w_cfg_we;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == csr_spmv_pkg::REG_NUM_COLS);
    assign prdata   = (paddr[2] == csr_spmv_pkg::REG_NUM_COLS) ? {19'd0, r_num_cols} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= csr_spmv_pkg::NUM_COLS_RESET;
        end else if (w_cfg_we) begin
            r_num_cols <= pwdata[12:0];
        end
    end

    // input transfer and column checks
    assign i_in.ready = !w_stall;
    assign w_accept   = i_in.valid && !w_stall;
    assign w_col_ext  = {20'd0, i_in.data.column_index};
    assign w_addr     = w_col_ext[AW-1:0];
    assign w_in_store = w_col_ext < 32'(MAX_COLS);
    assign w_bad      = !w_in_store || ({1'b0, i_in.data.column_index} >= r_num_cols);
    assign w_load     = w_accept && (i_in.data.kind == csr_spmv_pkg::KIND_LOAD) && w_in_store;
    assign w_term     = w_accept && (i_in.data.kind == csr_spmv_pkg::KIND_TERM) && !w_bad;

    always_comb begin
        n_s1 = r_s1;
        if (!w_stall) begin
            n_s1.valid = i_in.valid;
            n_s1.kind  = i_in.data.kind;
            n_s1.bad   = w_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_data <= i_in.data.data_value;
        end
    end

    csr_spmv_vec_store #(
        .DEPTH (MAX_COLS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_addr),
        .i_wdata (i_in.data.data_value),
        .i_re    (w_term),
        .i_raddr (w_addr),
        .o_rdata (w_vec)
    );

    csr_spmv_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (r_s1),
        .i_mat       (r_s1_data),
        .i_vec       (w_vec),
        .i_out_ready (o_out.ready),
        .o_stall     (w_stall),
        .o_valid     (o_out.valid),
        .o_item      (o_out.data)
    );

    `CSM_ASSERT_NEXT(a_cfg_write, w_cfg_we, r_num_cols == $past(pwdata[12:0]))
    `CSM_ASSERT_IMPL(a_stall_needs_result, w_stall, o_out.valid && !o_out.ready)
    `CSM_ASSERT_NEXT(a_stall_holds_s1, w_stall, $stable(r_s1))

endmodule
